[hdl/fipsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fipsd_pkg
// Shared types, widths and constants of the inverse Park / SVPWM duty block.
// ----------------------------------------------------------------------------
package fipsd_pkg;

   localparam int ANGLE_BITS   = 12;
   localparam int DUTY_BITS    = 16;
   localparam int CMD_W        = 16;
   localparam int MAX_W        = 15;
   localparam int CSR_IDX_W    = 2;
   localparam int CORDIC_STEPS = 16;
   localparam int CW           = 34;
   localparam int ZW           = 34;
   localparam int TRIG_W       = 17;
   localparam int PROD_W       = 34;
   localparam int ALPHA_W      = 36;
   localparam int NW           = 58;
   localparam int QDEPTH       = 4;
   localparam int QAW          = 2;
   localparam int NDIV         = DUTY_BITS + 2;
   localparam int NST          = CORDIC_STEPS + 1 + 4 + NDIV;

   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [17:0]   SQRT3_HALF_Q16 = 18'sd56756;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd1;

   typedef enum logic {
      MODE_SINE = 1'b0,
      MODE_SVM  = 1'b1
   } mode_type;

   typedef struct packed {
      logic signed [CMD_W:0] d2;
      logic signed [CMD_W:0] q2;
      logic signed [31:0]    z;
      logic                  flip;
   } cmd_type;

   function automatic logic signed [ZW-1:0] atan_turn(input int idx);
      logic signed [ZW-1:0] r;
      unique case (idx)
         0:       r = 34'sd536870912;
         1:       r = 34'sd316933406;
         2:       r = 34'sd167458907;
         3:       r = 34'sd85004755;
         4:       r = 34'sd42667331;
         5:       r = 34'sd21354465;
         6:       r = 34'sd10679838;
         7:       r = 34'sd5340245;
         8:       r = 34'sd2670163;
         9:       r = 34'sd1335087;
         10:      r = 34'sd667544;
         11:      r = 34'sd333772;
         12:      r = 34'sd166886;
         13:      r = 34'sd83443;
         14:      r = 34'sd41722;
         15:      r = 34'sd20861;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/fipsd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fipsd_front
// Accepts request beats, clamps both commands and folds the angle.
// ----------------------------------------------------------------------------
module fipsd_front import fipsd_pkg::*; (
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [CMD_W-1:0] req_d_command,
   input  wire logic signed [CMD_W-1:0] req_q_command,
   input  wire logic [ANGLE_BITS-1:0]   req_electrical_angle,
   input  wire logic [MAX_W-1:0]        max_level,
   input  wire logic                    full,
   output logic                         push,
   output cmd_type                      cmd
);

   logic signed [CMD_W:0] lim;
   logic signed [CMD_W:0] nlim;
   logic signed [CMD_W:0] d2_raw;
   logic signed [CMD_W:0] q2_raw;
   logic [31:0]           p;

   assign req_stall = full;
   assign push      = req_valid && !full;

   always_comb begin
      lim    = $signed({2'b00, max_level});
      nlim   = -lim;
      d2_raw = $signed({req_d_command, 1'b0});
      q2_raw = $signed({req_q_command, 1'b0});
      p      = {req_electrical_angle, {(32-ANGLE_BITS){1'b0}}};

      priority if (d2_raw > lim) cmd.d2 = lim;
      else if (d2_raw < nlim)    cmd.d2 = nlim;
      else                       cmd.d2 = d2_raw;

      priority if (q2_raw > lim) cmd.q2 = lim;
      else if (q2_raw < nlim)    cmd.q2 = nlim;
      else                       cmd.q2 = q2_raw;

      cmd.flip = p[31] ^ p[30];
      cmd.z    = cmd.flip ? $signed({~p[31], p[30:0]}) : $signed(p);
   end

endmodule
`default_nettype wire

[hdl/fipsd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fipsd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module fipsd_queue import fipsd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      pop_data
);

   cmd_type           mem_ff [QDEPTH];
   logic [QAW-1:0]    wr_ff, wr_in;
   logic [QAW-1:0]    rd_ff, rd_in;
   logic [QAW:0]      count_ff, count_in;

   assign full     = count_ff == (QAW+1)'(QDEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop  ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAW+1)'(QDEPTH))
      else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

[hdl/fipsd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fipsd_back
// CORDIC sine/cosine, inverse Park/Clarke, midpoint injection and the
// pipelined duty divider with the result register.
// ----------------------------------------------------------------------------
module fipsd_back import fipsd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 empty,
   input  wire cmd_type              cmd,
   output logic                      pop,
   input  wire logic [MAX_W-1:0]     max_level,
   input  wire mode_type             mode,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [DUTY_BITS-1:0]      rsp_duty_a,
   output logic [DUTY_BITS-1:0]      rsp_duty_b,
   output logic [DUTY_BITS-1:0]      rsp_duty_c
);

   logic                 adv;
   logic [NST-1:0]       valid_ff;
   logic                 rsp_valid_ff;

   // CORDIC stages
   logic signed [CW-1:0]  x_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]  y_ff [CORDIC_STEPS+1];
   logic signed [ZW-1:0]  z_ff [CORDIC_STEPS+1];
   logic                  flip_ff [CORDIC_STEPS+1];
   logic signed [CMD_W:0] d2_ff [CORDIC_STEPS+1];
   logic signed [CMD_W:0] q2_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]  x_in [CORDIC_STEPS];
   logic signed [CW-1:0]  y_in [CORDIC_STEPS];
   logic signed [ZW-1:0]  z_in [CORDIC_STEPS];

   // trig stage
   logic signed [CW-1:0]     xf, yf, xr, yr;
   logic signed [TRIG_W-1:0] c_ff, c_in, s_ff, s_in;
   logic signed [CMD_W:0]    d2t_ff, q2t_ff;

   // product stage
   logic signed [PROD_W-1:0]  cd, sq, sd, cq;
   logic signed [ALPHA_W-1:0] alpha_ff, alpha_in, beta_ff, beta_in;

   // phase stage
   logic signed [53:0]  kb;
   logic signed [NW-1:0] ph_ff [3];
   logic signed [NW-1:0] ph_in [3];

   // midpoint stage
   logic signed [NW-1:0] lo, hi;
   logic signed [NW-1:0] mid_ff, mid_in;
   logic signed [NW-1:0] phm_ff [3];

   // divider stages
   logic signed [NW-1:0]  f2 [3];
   logic [NW-1:0]         rem_ff [3][NDIV];
   logic [DUTY_BITS-1:0]  quo_ff [3][NDIV];
   logic                  sat_ff [3][NDIV];
   logic                  pos_ff [3][NDIV];
   logic [DUTY_BITS-1:0]  duty_ff [3];
   logic [DUTY_BITS-1:0]  duty_in [3];

   assign adv        = !(rsp_valid_ff && rsp_stall);
   assign pop        = adv && !empty;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty_a = duty_ff[0];
   assign rsp_duty_b = duty_ff[1];
   assign rsp_duty_c = duty_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[NST-2:0], pop};
         rsp_valid_ff <= valid_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= ZW'(cmd.z);
         flip_ff[0] <= cmd.flip;
         d2_ff[0]   <= cmd.d2;
         q2_ff[0]   <= cmd.q2;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      always_comb begin
         if (!z_ff[i][ZW-1]) begin
            x_in[i] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i] = z_ff[i] - atan_turn(i);
         end else begin
            x_in[i] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i] = z_ff[i] + atan_turn(i);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i+1]    <= x_in[i];
            y_ff[i+1]    <= y_in[i];
            z_ff[i+1]    <= z_in[i];
            flip_ff[i+1] <= flip_ff[i];
            d2_ff[i+1]   <= d2_ff[i];
            q2_ff[i+1]   <= q2_ff[i];
         end
      end
   end

   always_comb begin
      xf   = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      yf   = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      xr   = (xf + 34'sd16384) >>> 15;
      yr   = (yf + 34'sd16384) >>> 15;
      c_in = xr[TRIG_W-1:0];
      s_in = yr[TRIG_W-1:0];
   end

   always_comb begin
      cd       = c_ff * d2t_ff;
      sq       = s_ff * q2t_ff;
      sd       = s_ff * d2t_ff;
      cq       = c_ff * q2t_ff;
      alpha_in = ALPHA_W'(cd) - ALPHA_W'(sq);
      beta_in  = ALPHA_W'(sd) + ALPHA_W'(cq);
   end

   always_comb begin
      kb       = beta_ff * SQRT3_HALF_Q16;
      ph_in[0] = NW'(alpha_ff) <<< 16;
      ph_in[1] = -(NW'(alpha_ff) <<< 15) + NW'(kb);
      ph_in[2] = -(NW'(alpha_ff) <<< 15) - NW'(kb);
   end

   always_comb begin
      lo = ph_ff[0];
      hi = ph_ff[0];
      for (int k = 1; k < 3; k++) begin
         if (ph_ff[k] < lo) lo = ph_ff[k];
         if (ph_ff[k] > hi) hi = ph_ff[k];
      end
      mid_in = (mode == MODE_SVM) ? lo + hi : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff     <= c_in;
         s_ff     <= s_in;
         d2t_ff   <= d2_ff[CORDIC_STEPS];
         q2t_ff   <= q2_ff[CORDIC_STEPS];
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
         ph_ff    <= ph_in;
         mid_ff   <= mid_in;
         phm_ff   <= ph_ff;
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      always_comb begin
         f2[l] = (phm_ff[l] <<< 1) + (NW'(max_level) <<< 32) - mid_ff;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[l][0] <= NW'(f2[l] + (NW'(max_level) <<< (32 - DUTY_BITS)));
            quo_ff[l][0] <= '0;
            sat_ff[l][0] <= 1'b0;
            pos_ff[l][0] <= f2[l] > 0;
         end
      end

      for (genvar j = 0; j < NDIV-1; j++) begin : g_div
         logic [NW-1:0] den;
         logic          ge;
         assign den = NW'(max_level) << (33 - j);
         assign ge  = rem_ff[l][j] >= den;
         if (j == 0) begin : g_sat
            always_ff @(posedge clock) begin
               if (adv) begin
                  rem_ff[l][j+1] <= rem_ff[l][j];
                  quo_ff[l][j+1] <= '0;
                  sat_ff[l][j+1] <= ge;
                  pos_ff[l][j+1] <= pos_ff[l][j];
               end
            end
         end else begin : g_bit
            always_ff @(posedge clock) begin
               if (adv) begin
                  rem_ff[l][j+1] <= ge ? rem_ff[l][j] - den : rem_ff[l][j];
                  quo_ff[l][j+1] <= {quo_ff[l][j][DUTY_BITS-2:0], ge};
                  sat_ff[l][j+1] <= sat_ff[l][j];
                  pos_ff[l][j+1] <= pos_ff[l][j];
               end
            end
         end
      end

      always_comb begin
         priority if (!pos_ff[l][NDIV-1]) duty_in[l] = '0;
         else if (sat_ff[l][NDIV-1])      duty_in[l] = '1;
         else                             duty_in[l] = quo_ff[l][NDIV-1];
      end

      always_ff @(posedge clock) begin
         if (adv && valid_ff[NST-1]) begin
            duty_ff[l] <= duty_in[l];
         end
      end
   end

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(valid_ff))
      else $error("pipeline moved while result stalled");
   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid_ff[NST-1]))
      else $error("result without pipeline beat");
`endif

endmodule
`default_nettype wire

[hdl/foc_inverse_park_svpwm_duty.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// foc_inverse_park_svpwm_duty
// Turns d/q voltage commands and an electrical angle into three PWM duties.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle while req_stall is low, and each result
// passes a 16-step CORDIC for sine and cosine, four arithmetic stages and
// a 17-step pipelined restoring divider. A four-entry queue sits between
// the input side and the arithmetic pipeline, so req_stall rises only
// after the result side has stalled long enough to fill it.
// Write max_level and modulation_mode only while no beat is in flight.
// ----------------------------------------------------------------------------
module foc_inverse_park_svpwm_duty import fipsd_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [CMD_W-1:0] req_d_command,
   input  wire logic signed [CMD_W-1:0] req_q_command,
   input  wire logic [ANGLE_BITS-1:0]   req_electrical_angle,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [DUTY_BITS-1:0]         rsp_duty_a,
   output logic [DUTY_BITS-1:0]         rsp_duty_b,
   output logic [DUTY_BITS-1:0]         rsp_duty_c,
   input  wire logic                    csr_write,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [MAX_W-1:0]        csr_data
);

   logic [MAX_W-1:0] max_level_ff;
   mode_type         mode_ff;
   logic             push, full, pop, empty;
   cmd_type          push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff <= '0;
         mode_ff      <= MODE_SINE;
      end else if (csr_write) begin
         if (csr_index == CSR_MAX_LEVEL) max_level_ff <= csr_data;
         if (csr_index == CSR_MODE)      mode_ff      <= mode_type'(csr_data[0]);
      end
   end

   fipsd_front u_front (
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_d_command        (req_d_command),
      .req_q_command        (req_q_command),
      .req_electrical_angle (req_electrical_angle),
      .max_level            (max_level_ff),
      .full                 (full),
      .push                 (push),
      .cmd                  (push_cmd)
   );

   fipsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (pop_cmd)
   );

   fipsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .cmd        (pop_cmd),
      .pop        (pop),
      .max_level  (max_level_ff),
      .mode       (mode_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_duty_a (rsp_duty_a),
      .rsp_duty_b (rsp_duty_b),
      .rsp_duty_c (rsp_duty_c)
   );

endmodule
`default_nettype wire

[sim/tb_foc_inverse_park_svpwm_duty.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_foc_inverse_park_svpwm_duty
// Self-checking bench for the inverse Park / SVPWM duty block: directed and
// random d/q/angle beats under both modulation modes and several bus levels,
// with random gaps on both channels, checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_foc_inverse_park_svpwm_duty;
   import fipsd_pkg::*;

   localparam int RUN_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [DUTY_BITS-1:0] a;
      logic [DUTY_BITS-1:0] b;
      logic [DUTY_BITS-1:0] c;
   } duty_set_type;

   typedef struct {
      logic signed [CMD_W-1:0] d;
      logic signed [CMD_W-1:0] q;
      logic [ANGLE_BITS-1:0]   ang;
      bit                      known;
      duty_set_type            want;
   } vec_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CMD_W-1:0] req_d_command = '0;
   logic signed [CMD_W-1:0] req_q_command = '0;
   logic [ANGLE_BITS-1:0] req_electrical_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DUTY_BITS-1:0] rsp_duty_a, rsp_duty_b, rsp_duty_c;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MAX_W-1:0] csr_data = '0;

   longint unsigned bus_level;
   mode_type mod_mode;
   duty_set_type pending_duties[$];
   int fail_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit stim_done = 1'b0;

   foc_inverse_park_svpwm_duty uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void trig(input logic [ANGLE_BITS-1:0] ang,
                                output longint cs, output longint sn);
      longint atab[16] = '{536870912, 316933406, 167458907, 85004755, 42667331,
                           21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                           333772, 166886, 83443, 41722, 20861};
      logic [31:0] p;
      bit flip;
      longint x, y, z, nx;
      p = {ang, {(32 - ANGLE_BITS){1'b0}}};
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (p >= 32'h4000_0000 && p < 32'hC000_0000) begin
         p = p - 32'h8000_0000;
         flip = 1'b1;
      end
      z = longint'($signed(p));
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - floor_sh(y, i);
            y = y + floor_sh(x, i);
            z -= atab[i];
         end else begin
            nx = x + floor_sh(y, i);
            y = y - floor_sh(x, i);
            z += atab[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cs = floor_sh(x + 16384, 15);
      sn = floor_sh(y + 16384, 15);
   endfunction

   function automatic longint clamp2(logic signed [CMD_W-1:0] v, longint lim);
      longint r;
      r = 2 * longint'(v);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic logic [DUTY_BITS-1:0] scale_duty(longint f2, longint den);
      longint qv;
      if (f2 <= 0) return '0;
      qv = (f2 + den / 2) / den;
      if (qv > 65535) qv = 65535;
      return qv[DUTY_BITS-1:0];
   endfunction

   function automatic duty_set_type modulate(logic signed [CMD_W-1:0] d,
                                             logic signed [CMD_W-1:0] q,
                                             logic [ANGLE_BITS-1:0] ang);
      duty_set_type r;
      longint m, d2, q2, cs, sn, al, be, base, den, lo, hi;
      longint ph[3];
      m = longint'(bus_level);
      if (m == 0) return '0;
      d2 = clamp2(d, m);
      q2 = clamp2(q, m);
      trig(ang, cs, sn);
      al = cs * d2 - sn * q2;
      be = sn * d2 + cs * q2;
      ph[0] = al * 65536;
      ph[1] = -al * 32768 + 56756 * be;
      ph[2] = -al * 32768 - 56756 * be;
      base = m * 64'd4294967296;
      if (mod_mode == MODE_SVM) begin
         lo = ph[0];
         hi = ph[0];
         for (int k = 1; k < 3; k++) begin
            if (ph[k] < lo) lo = ph[k];
            if (ph[k] > hi) hi = ph[k];
         end
         base -= lo + hi;
      end
      den = m << (33 - DUTY_BITS);
      r.a = scale_duty(2 * ph[0] + base, den);
      r.b = scale_duty(2 * ph[1] + base, den);
      r.c = scale_duty(2 * ph[2] + base, den);
      return r;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [MAX_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MAX_LEVEL) bus_level = val;
      else if (idx == CSR_MODE) mod_mode = mode_type'(val[0]);
   endtask

   task automatic set_mode(logic [MAX_W-1:0] lvl, mode_type md);
      wait (pending_duties.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_reg(CSR_MAX_LEVEL, lvl);
      write_reg(CSR_MODE, {{(MAX_W - 1){1'b0}}, md});
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_beat(logic signed [CMD_W-1:0] d, logic signed [CMD_W-1:0] q,
                            logic [ANGLE_BITS-1:0] ang, bit burst);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_d_command <= d;
      req_q_command <= q;
      req_electrical_angle <= ang;
      pending_duties.push_back(modulate(d, q, ang));
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_idle();
      req_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= pick_gap();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      duty_set_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_duty_a, rsp_duty_b, rsp_duty_c};
         if (pending_duties.size() == 0) begin
            $error("unexpected result beat");
            fail_count++;
         end else begin
            want = pending_duties.pop_front();
            if (got.a !== want.a) begin
               $error("duty_a expected %0d got %0d", want.a, got.a);
               fail_count++;
            end
            if (got.b !== want.b) begin
               $error("duty_b expected %0d got %0d", want.b, got.b);
               fail_count++;
            end
            if (got.c !== want.c) begin
               $error("duty_c expected %0d got %0d", want.c, got.c);
               fail_count++;
            end
         end
      end
   end

   vec_row_type vectors[] = '{
      '{16'sd1000, 16'sd0, 12'd0, 1'b1, '0},
      '{16'sd0, 16'sd0, 12'd0, 1'b0, '0},
      '{16'sd32767, 16'sd0, 12'd0, 1'b0, '0},
      '{-16'sd32768, 16'sd0, 12'd0, 1'b0, '0},
      '{16'sd0, 16'sd32767, 12'd1024, 1'b0, '0},
      '{16'sd0, -16'sd32768, 12'd2048, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 12'd3072, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, 12'd4095, 1'b0, '0},
      '{16'sd100, -16'sd50, 12'd1023, 1'b0, '0},
      '{-16'sd77, 16'sd300, 12'd3071, 1'b0, '0},
      '{16'sd5000, 16'sd5000, 12'd512, 1'b0, '0},
      '{16'sd1, 16'sd1, 12'd2047, 1'b0, '0}
   };

   initial begin
      static logic [MAX_W-1:0] levels[4] = '{15'd32767, 15'd1, 15'd1000, 15'd20000};
      logic signed [CMD_W-1:0] d, q;
      bus_level = 0;
      mod_mode = MODE_SINE;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Reset leaves max_level at zero: every duty reads zero.
      foreach (vectors[i]) if (vectors[i].known) begin
         send_beat(vectors[i].d, vectors[i].q, vectors[i].ang, 1'b0);
         if (pending_duties[$] !== vectors[i].want) begin
            $error("duty_a expected %0d got %0d", vectors[i].want.a, pending_duties[$].a);
            fail_count++;
         end
      end
      send_idle();
      for (int ph = 0; ph < 8; ph++) begin
         set_mode(levels[ph % 4], mode_type'(ph / 4));
         foreach (vectors[i]) send_beat(vectors[i].d, vectors[i].q, vectors[i].ang, 1'b0);
         for (int n = 0; n < 170; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               d = CMD_W'($urandom);
               q = CMD_W'($urandom);
            end else begin
               d = $signed(16'($urandom_range(0, 2 * levels[ph % 4]))) -
                   $signed(16'(levels[ph % 4]));
               q = $signed(16'($urandom_range(0, 2 * levels[ph % 4]))) -
                   $signed(16'(levels[ph % 4]));
            end
            send_beat(d, q, ANGLE_BITS'($urandom), n > 100 && n < 130);
         end
         send_idle();
      end
      set_mode(15'd0, MODE_SVM);
      for (int n = 0; n < 20; n++) begin
         send_beat(CMD_W'($urandom), CMD_W'($urandom), ANGLE_BITS'($urandom), 1'b0);
      end
      send_idle();
      wait (pending_duties.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
